// ===== sv/bbf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bounded byte stream FIFO.
package bbf_pkg;

    localparam int CW = 13;                      // count, capacity and pop width
    localparam logic [CW-1:0] CAP_RESET = 13'd4096;

    typedef enum logic [1:0] {
        FN_PUSH  = 2'd0,
        FN_POP   = 2'd1,
        FN_CLOSE = 2'd2,
        FN_QUERY = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE   = 2'd0,
        ST_FULL   = 2'd1,
        ST_CLOSED = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    typedef struct packed {
        t_func           func;
        logic [7:0]      push_byte;
        logic [CW-1:0]   pop_count;
    } t_req;

    typedef struct packed {
        t_status         status;
        logic [7:0]      head_byte;
        logic            head_valid;
        logic [CW-1:0]   fill_level;
        logic [CW-1:0]   free_space;
        logic [63:0]     total_pushed;
        logic [63:0]     total_popped;
        logic            stream_closed;
        logic            stream_done;
    } t_rsp;

    // Controller to datapath commands
    typedef struct packed {
        logic take;     // latch the accepted request
        logic exec;     // apply the operation to queue state
        logic rd;       // read the head entry of the store
        logic load;     // fill the result register
    } t_cmd;

endpackage

// ===== sv/bbf_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results.
interface bbf_req_if import bbf_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bbf_rsp_if import bbf_pkg::*; ();
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/bbf_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencing state machine and result-valid flag of the byte FIFO.
module bbf_ctrl import bbf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    input  logic i_rsp_ready,
    output logic o_req_ready,
    output logic o_rsp_valid,
    output t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_WAIT = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   slot_free;

    // Hold the input closed while reset is applied
    assign o_req_ready = i_rst_n && (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign slot_free   = !r_rsp_valid || i_rsp_ready;

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.rd = 1'b1;
                n_state  = S_WAIT;
            end
            S_WAIT: begin
                if (slot_free) begin
                    o_cmd.load  = 1'b1;
                    n_rsp_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

endmodule

// ===== sv/bbf_dpath.sv =====
`timescale 1ns / 1ps
// Byte store, pointers, counters, capacity register and result register.
module bbf_dpath import bbf_pkg::*; #(
    parameter int DEPTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_cmd          i_cmd,
    input  t_req          i_req,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_wdata,
    output t_rsp          o_rsp
);

    localparam int PW = $clog2(DEPTH);
    localparam int SW = ((PW > CW) ? PW : CW) + 1;

    logic [7:0] mem [DEPTH];

    t_req          r_req;
    logic [PW-1:0] r_rp, n_rp, r_wp, n_wp;
    logic [CW-1:0] r_fill, n_fill, r_cap;
    logic          r_closed, n_closed;
    logic [63:0]   r_pushed, n_pushed, r_popped, n_popped;
    t_status       r_status, n_status;
    logic [7:0]    r_rdata;
    t_rsp          r_rsp;

    logic [CW-1:0] cap_eff, take_n, free_sp;
    logic [SW-1:0] rp_sum;
    logic          wr_en;

    // Saturate the capacity at the store depth
    always_comb begin
        if (SW'(r_cap) > SW'(DEPTH)) cap_eff = CW'(DEPTH);
        else                         cap_eff = r_cap;
    end

    assign take_n = (r_req.pop_count < r_fill) ? r_req.pop_count : r_fill;
    assign rp_sum = SW'(r_rp) + SW'(take_n);

    always_comb begin
        n_rp     = r_rp;
        n_wp     = r_wp;
        n_fill   = r_fill;
        n_closed = r_closed;
        n_pushed = r_pushed;
        n_popped = r_popped;
        n_status = ST_DONE;
        wr_en    = 1'b0;
        case (r_req.func)
            FN_PUSH: begin
                if (r_closed) begin
                    n_status = ST_CLOSED;
                end else if (r_fill >= cap_eff) begin
                    n_status = ST_FULL;
                end else begin
                    wr_en    = 1'b1;
                    n_wp     = (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    n_fill   = r_fill + 1'b1;
                    n_pushed = r_pushed + 64'd1;
                end
            end
            FN_POP: begin
                if (r_fill == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_rp     = (rp_sum >= SW'(DEPTH)) ? PW'(rp_sum - SW'(DEPTH))
                                                      : PW'(rp_sum);
                    n_fill   = r_fill - take_n;
                    n_popped = r_popped + 64'(take_n);
                end
            end
            FN_CLOSE: n_closed = 1'b1;
            default:  n_status = ST_DONE;
        endcase
    end

    assign free_sp = (r_fill >= cap_eff) ? '0 : cap_eff - r_fill;

    always_ff @(posedge i_clk) begin
        if (wr_en && i_cmd.exec) begin
            mem[r_wp] <= r_req.push_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
        if (i_cmd.load) begin
            r_rsp.status        <= r_status;
            r_rsp.head_byte     <= (r_fill != '0) ? r_rdata : 8'd0;
            r_rsp.head_valid    <= (r_fill != '0);
            r_rsp.fill_level    <= r_fill;
            r_rsp.free_space    <= free_sp;
            r_rsp.total_pushed  <= r_pushed;
            r_rsp.total_popped  <= r_popped;
            r_rsp.stream_closed <= r_closed;
            r_rsp.stream_done   <= r_closed && (r_fill == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp     <= '0;
            r_wp     <= '0;
            r_fill   <= '0;
            r_closed <= 1'b0;
            r_pushed <= '0;
            r_popped <= '0;
            r_cap    <= CAP_RESET;
        end else begin
            if (i_cmd.exec) begin
                r_rp     <= n_rp;
                r_wp     <= n_wp;
                r_fill   <= n_fill;
                r_closed <= n_closed;
                r_pushed <= n_pushed;
                r_popped <= n_popped;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

// ===== sv/bounded_byte_stream_fifo_core.sv =====
`timescale 1ns / 1ps
// Top level of the bounded byte stream FIFO: one result per request.
// After accept, a request steps through execute, store read and load; the load waits for a free result slot.
// The next request is taken only once the accept/execute/store-read/load sequence around the
// single-port byte store has finished and the result has been loaded into the result slot.
// Reset: synchronous active-low i_rst_n empties the queue, clears the totals and closed flag,
// and sets capacity to 4096; store contents are left as they are.
module bounded_byte_stream_fifo_core import bbf_pkg::*; #(
    parameter int DEPTH = 4096
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bbf_req_if.sink       i_req,
    bbf_rsp_if.source     o_rsp,
    input  logic          i_cfg_we,
    input  logic [CW-1:0] i_cfg_wdata
);

    t_cmd cmd;
    logic req_ready;
    logic rsp_valid;

    // Sequencer: takes one request, then steps it through execute, head read and load.
    // The result register is refilled only once its previous result has been taken.
    bbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_req_ready (req_ready),
        .o_rsp_valid (rsp_valid),
        .o_cmd       (cmd)
    );

    // Queue state and byte store; the head byte is read after the update so that a
    // push into an empty queue shows its own byte.
    bbf_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_req       (i_req.data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_rsp       (o_rsp.data)
    );

    // Drive handshake lines of both channels
    assign i_req.ready = req_ready;
    assign o_rsp.valid = rsp_valid;

endmodule

// ===== sv/bbf_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the byte FIFO top level, with its bind.
module bbf_chk import bbf_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_req_valid,
    input logic i_req_ready,
    input logic i_rsp_valid,
    input logic i_rsp_ready,
    input t_rsp i_rsp_data
);

    // A held result request keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("result dropped or changed while stalled");

    // One request at a time: the input closes right after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request accepted while another is in flight");

    a_head_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (i_rsp_data.head_valid == (i_rsp_data.fill_level != '0))
                     && (i_rsp_data.head_valid || i_rsp_data.head_byte == 8'd0))
        else $error("head byte flags disagree with fill level");

    a_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_rsp_data.stream_done ==
                        (i_rsp_data.stream_closed && !i_rsp_data.head_valid))
        else $error("finished flag inconsistent");

endmodule

bind bounded_byte_stream_fifo_core bbf_chk u_bbf_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

// ===== tb/tb_bounded_byte_stream_fifo_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bounded byte stream FIFO core, with a shadow queue model.
module tb_bounded_byte_stream_fifo_core;
    import bbf_pkg::*;

    localparam int DEPTH         = 4096;
    localparam int CAP_MAX       = (1 << CW) - 1;
    localparam int SETTLE_CYCLES = 6;      // block latency plus margin
    localparam int MAX_PRINTS    = 100;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CW-1:0] i_cfg_wdata;

    bbf_req_if req_ch ();
    bbf_rsp_if rsp_ch ();

    bounded_byte_stream_fifo_core #(
        .DEPTH (DEPTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Shadow copy of the queue: byte store, pointers, fill, flag, totals and capacity.
    logic [7:0]    shadow_bytes [DEPTH];
    int unsigned   shadow_rd     = 0;
    int unsigned   shadow_wr     = 0;
    int unsigned   shadow_fill   = 0;
    logic          shadow_closed = 1'b0;
    logic [63:0]   shadow_pushed = '0;
    logic [63:0]   shadow_popped = '0;
    logic [CW-1:0] shadow_cap    = CAP_RESET;

    // Queue state each accepted request should report, oldest first.
    t_rsp pending_results [$];

    int  mismatch_count = 0;
    int  result_count   = 0;
    bit  no_gaps        = 1'b0;   // set for back-to-back stretches on both sides

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Draw the idle cycles one side spends before its next request or result.
    function automatic int draw_wait();
        return no_gaps ? 0 : $urandom_range(0, 6);
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTS)
            $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0h expected %0h",
                                      result_count, name, got, want));
    endtask

    // Apply one accepted request to the shadow queue and queue up the state it must report.
    // Closed is checked ahead of full; a pop takes at most what is held; capacity above
    // DEPTH saturates; a capacity under the fill leaves the held bytes in place.
    task automatic predict_queue_result(input t_req r);
        t_rsp        want;
        int unsigned eff_cap;
        int unsigned take;
        want        = '0;
        want.status = ST_DONE;
        eff_cap     = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
        case (r.func)
            FN_PUSH: begin
                if (shadow_closed) begin
                    want.status = ST_CLOSED;
                end else if (shadow_fill >= eff_cap) begin
                    want.status = ST_FULL;
                end else begin
                    shadow_bytes[shadow_wr] = r.push_byte;
                    shadow_wr     = (shadow_wr + 1) % DEPTH;
                    shadow_fill   = shadow_fill + 1;
                    shadow_pushed = shadow_pushed + 64'd1;
                end
            end
            FN_POP: begin
                if (shadow_fill == 0) begin
                    want.status = ST_EMPTY;
                end else begin
                    take          = (r.pop_count < shadow_fill) ? r.pop_count : shadow_fill;
                    shadow_rd     = (shadow_rd + take) % DEPTH;
                    shadow_fill   = shadow_fill - take;
                    shadow_popped = shadow_popped + 64'(take);
                end
            end
            FN_CLOSE: shadow_closed = 1'b1;
            default: ;
        endcase
        want.head_valid    = (shadow_fill != 0);
        want.head_byte     = (shadow_fill != 0) ? shadow_bytes[shadow_rd] : 8'h00;
        want.fill_level    = CW'(shadow_fill);
        want.free_space    = CW'((shadow_fill >= eff_cap) ? 0 : eff_cap - shadow_fill);
        want.total_pushed  = shadow_pushed;
        want.total_popped  = shadow_popped;
        want.stream_closed = shadow_closed;
        want.stream_done   = shadow_closed && (shadow_fill == 0);
        pending_results.push_back(want);
    endtask

    // Send one request. Enter anywhere after a rising edge; return at the accepting edge
    // with valid still high, so a following call can keep it up without a drop.
    task automatic send_req(input t_func f, input logic [7:0] b, input logic [CW-1:0] n);
        t_req r;
        int   gap;
        r   = '{func: f, push_byte: b, pop_count: n};
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= r;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        predict_queue_result(r);
    endtask

    // Drop valid and hold off until every expected result is back, then let the block settle.
    task automatic hold_until_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the capacity register; only ever done with the block idle.
    task automatic write_capacity(input logic [CW-1:0] value);
        hold_until_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        shadow_cap  = value;
    endtask

    // Result side: stall a random number of cycles per result, then take it.
    initial begin : rsp_sink
        int stall;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            stall = draw_wait();
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (rsp_ch.valid !== 1'b1);
        end
    end

    // Compare every accepted result against the oldest pending expectation.
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (i_rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            got = rsp_ch.data;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no request pending",
                                          result_count));
            end else begin
                want = pending_results.pop_front();
                check_field("status",        got.status,        want.status);
                check_field("head_byte",     got.head_byte,     want.head_byte);
                check_field("head_valid",    got.head_valid,    want.head_valid);
                check_field("fill_level",    got.fill_level,    want.fill_level);
                check_field("free_space",    got.free_space,    want.free_space);
                check_field("total_pushed",  got.total_pushed,  want.total_pushed);
                check_field("total_popped",  got.total_popped,  want.total_popped);
                check_field("stream_closed", got.stream_closed, want.stream_closed);
                check_field("stream_done",   got.stream_done,   want.stream_done);
            end
            result_count++;
        end
    end

    // Query right after reset, then pop an empty queue with zero and nonzero counts.
    task automatic test_reset_state();
        send_req(FN_QUERY, 8'h00, '0);
        send_req(FN_POP, 8'h00, '0);
        send_req(FN_POP, 8'h00, 13'd5);
    endtask

    // Extreme byte values, zero pop on a non-empty queue, pop beyond the fill.
    task automatic test_push_pop();
        send_req(FN_PUSH, 8'h00, '0);
        send_req(FN_PUSH, 8'hFF, 13'h1FFF);
        send_req(FN_PUSH, 8'hA5, '0);
        send_req(FN_QUERY, 8'h5A, '0);
        send_req(FN_POP, 8'h00, '0);
        send_req(FN_POP, 8'h00, 13'd1);
        send_req(FN_POP, 8'h00, 13'd100);
        send_req(FN_POP, 8'h00, 13'd1);
    endtask

    // Full at a small capacity, capacity dropped under the fill, capacity zero,
    // and capacity above DEPTH saturating.
    task automatic test_capacity_limits();
        write_capacity(13'd2);
        send_req(FN_PUSH, 8'h11, '0);
        send_req(FN_PUSH, 8'h22, '0);
        send_req(FN_PUSH, 8'h33, '0);
        write_capacity(13'd1);
        send_req(FN_PUSH, 8'h44, '0);
        send_req(FN_POP, 8'h00, 13'd1);
        send_req(FN_PUSH, 8'h55, '0);
        send_req(FN_POP, 8'h00, 13'd1);
        send_req(FN_PUSH, 8'h66, '0);
        write_capacity(13'd0);
        send_req(FN_PUSH, 8'h77, '0);
        send_req(FN_POP, 8'h00, 13'h1FFF);
        send_req(FN_PUSH, 8'h88, '0);
        write_capacity(13'h1FFF);
        send_req(FN_QUERY, 8'h00, '0);
    endtask

    // Random mix of pushes, pops, queries and, when allowed, closes, with random content in every field.
    // Pop counts mostly stay small so the queue fills and drains repeatedly.
    task automatic run_random_phase(input int count, input int push_pct,
                                    input bit allow_close, input bit bursty);
        int            pick;
        t_func         f;
        logic [CW-1:0] n;
        no_gaps = bursty;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < push_pct)
                f = FN_PUSH;
            else if (pick < push_pct + 25)
                f = FN_POP;
            else if (allow_close && pick >= 97)
                f = FN_CLOSE;
            else
                f = FN_QUERY;
            case ($urandom_range(0, 15))
                0:       n = '0;
                1:       n = CW'($urandom_range(0, CAP_MAX));
                2:       n = 13'd4096;
                3, 4:    n = CW'($urandom_range(1, 64));
                default: n = CW'($urandom_range(1, 4));
            endcase
            send_req(f, 8'($urandom), n);
            // Now and then hold the sender until the queue of results is empty.
            if ($urandom_range(0, 199) == 0)
                hold_until_drained();
        end
        no_gaps = 1'b0;
    endtask

    // Sweep several capacities; the fill carries over, so some phases start above capacity.
    task automatic test_random_traffic();
        write_capacity(13'd5);
        run_random_phase(200, 50, 1'b0, 1'b0);
        write_capacity(13'd1);
        run_random_phase(150, 50, 1'b0, 1'b0);
        write_capacity(13'd64);
        run_random_phase(260, 65, 1'b0, 1'b1);
        write_capacity(13'd4096);
        run_random_phase(210, 60, 1'b0, 1'b0);
        write_capacity(13'd7);
        run_random_phase(200, 55, 1'b0, 1'b0);
        write_capacity(13'd0);
        run_random_phase(60, 40, 1'b0, 1'b0);
        write_capacity(CW'(CAP_MAX));
        run_random_phase(150, 50, 1'b0, 1'b0);
    endtask

    // Close on a full queue: closed wins over full, a second close is harmless,
    // pops still drain, and the finished flag rises once empty. Run last: no reopen.
    task automatic test_close_stream();
        write_capacity(13'd3);
        send_req(FN_POP, 8'h00, 13'h1FFF);
        send_req(FN_PUSH, 8'h01, '0);
        send_req(FN_PUSH, 8'h02, '0);
        send_req(FN_PUSH, 8'h03, '0);
        send_req(FN_PUSH, 8'h04, '0);
        send_req(FN_CLOSE, 8'h00, '0);
        send_req(FN_PUSH, 8'h05, '0);
        send_req(FN_CLOSE, 8'h00, '0);
        send_req(FN_POP, 8'h00, 13'd1);
        send_req(FN_QUERY, 8'h00, '0);
        send_req(FN_POP, 8'h00, 13'd8);
        send_req(FN_POP, 8'h00, '0);
        send_req(FN_PUSH, 8'hFF, '0);
        run_random_phase(80, 40, 1'b1, 1'b0);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_wdata  = '0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_push_pop();
        test_capacity_limits();
        test_random_traffic();
        test_close_stream();

        // Wait out every result, then watch a few more cycles for stray ones.
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("bounded_byte_stream_fifo_core verification clean");
        end else begin
            $display("bounded_byte_stream_fifo_core verification failed");
        end
        $finish;
    end

    // Watchdog: 10 ms, far beyond the slowest legal run.
    initial begin : watchdog
        #10_000_000;
        $display("bounded_byte_stream_fifo_core verification failed");
        $finish;
    end

endmodule
